/* rtl/ptsj_pkg.sv */
// ptsj_pkg: shared types, constants and the packet byte function
// for the pan/tilt servo jog packetizer; no dependencies
package ptsj_pkg;

  localparam int unsigned REG_W   = 10;
  localparam int unsigned PAN_W   = 12;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned BIDX_W  = 5;

  localparam logic [REG_W-1:0] PAN_HOME_RST   = 10'h200;
  localparam logic [REG_W-1:0] TILT_HOME_RST  = 10'h1EB;
  localparam logic [REG_W-1:0] TILT_LOW_RST   = 10'h060;
  localparam logic [REG_W-1:0] TILT_HIGH_RST  = 10'h36D;
  localparam logic [REG_W-1:0] PAN_HIGH_RST   = 10'h3FF;

  localparam logic [7:0] PKT_SYNC  = 8'hFF;
  localparam logic [7:0] PKT_LEN   = 8'h05;
  localparam logic [7:0] PKT_INSTR = 8'h03;
  localparam logic [7:0] PKT_ADDR  = 8'h1E;
  localparam logic [7:0] ID_PAN    = 8'h01;
  localparam logic [7:0] ID_TILT   = 8'h02;

  localparam logic [BIDX_W-1:0] LAST_SINGLE = 5'd8;
  localparam logic [BIDX_W-1:0] LAST_PAIR   = 5'd17;
  localparam logic [BIDX_W-1:0] PKT_BYTES   = 5'd9;

  typedef enum logic [2:0] {
    OP_HOME   = 3'd0,
    OP_WR_EN  = 3'd1,
    OP_DOWN   = 3'd2,
    OP_UP     = 3'd3,
    OP_LEFT   = 3'd4,
    OP_RIGHT  = 3'd5
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_PAN_HOME  = 3'd0,
    REG_TILT_HOME = 3'd1,
    REG_TILT_LOW  = 3'd2,
    REG_TILT_HIGH = 3'd3,
    REG_PAN_HIGH  = 3'd4
  } reg_idx_t;

  // one queued job: a single packet, or the pan+tilt pair of a home command
  typedef struct packed {
    logic             pair;
    logic [7:0]       id;
    logic [VAL_W-1:0] value;
    logic [REG_W-1:0] tilt_value;
    logic [3:0]       enables;
  } desc_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } q_status_t;

  function automatic logic [7:0] packet_byte(input logic [7:0] id,
                                             input logic [VAL_W-1:0] value,
                                             input logic [3:0] pos);
    logic [7:0] sum;
    logic [7:0] b;
    sum = id + PKT_LEN + PKT_INSTR + PKT_ADDR + value[7:0] + value[15:8];
    case (pos)
      4'd0, 4'd1: b = PKT_SYNC;
      4'd2:       b = id;
      4'd3:       b = PKT_LEN;
      4'd4:       b = PKT_INSTR;
      4'd5:       b = PKT_ADDR;
      4'd6:       b = value[7:0];
      4'd7:       b = value[15:8];
      default:    b = ~sum;
    endcase
    return b;
  endfunction

endpackage

/* rtl/ptsj_if.sv */
// ptsj_cmd_if, ptsj_pkt_if: valid/ready channels for commands and packet bytes
// no dependencies
interface ptsj_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [3:0] enable_bits;
  modport source (output valid, output op, output enable_bits, input ready);
  modport sink   (input valid, input op, input enable_bits, output ready);
endinterface

interface ptsj_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic [3:0] enables_now;
  modport source (output valid, output out_byte, output last_byte, output enables_now,
                  input ready);
  modport sink   (input valid, input out_byte, input last_byte, input enables_now,
                  output ready);
endinterface

/* rtl/ptsj_front.sv */
// ptsj_front: config registers, position and jog-enable state, command decode
// depends on ptsj_pkg and ptsj_cmd_if
module ptsj_front (
  input  logic                clk,
  input  logic                rst,
  ptsj_cmd_if.sink            cmd,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [9:0]          cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output ptsj_pkg::desc_t     q_desc
);
  import ptsj_pkg::*;

  logic [REG_W-1:0]        pan_home, tilt_home, tilt_low, tilt_high, pan_high;
  logic [REG_W-1:0]        tilt_pos, tilt_pos_next;
  logic signed [PAN_W-1:0] pan_pos, pan_pos_next;
  logic [3:0]              enables, enables_next;
  logic                    accept;
  logic                    emit;
  desc_t                   desc;

  assign cmd.ready = !q_full;
  assign accept    = cmd.valid && cmd.ready;

  always_comb begin
    tilt_pos_next   = tilt_pos;
    pan_pos_next    = pan_pos;
    enables_next    = enables;
    emit            = 1'b0;
    desc.pair       = 1'b0;
    desc.id         = ID_TILT;
    desc.value      = {{(VAL_W-REG_W){1'b0}}, tilt_pos};
    desc.tilt_value = tilt_home;
    unique case (op_t'(cmd.op))
      OP_HOME: begin
        pan_pos_next  = $signed({{(PAN_W-REG_W){1'b0}}, pan_home});
        tilt_pos_next = tilt_home;
        emit          = 1'b1;
        desc.pair     = 1'b1;
        desc.id       = ID_PAN;
        desc.value    = {{(VAL_W-REG_W){1'b0}}, pan_home};
      end
      OP_WR_EN: enables_next = cmd.enable_bits;
      OP_DOWN: begin
        if (enables[1]) begin
          enables_next[0] = 1'b0;
          if (tilt_pos >= tilt_low) begin
            tilt_pos_next = tilt_pos - 10'd1;
            emit          = 1'b1;
            desc.value    = {{(VAL_W-REG_W){1'b0}}, tilt_pos_next};
          end else begin
            enables_next[1] = 1'b0;
          end
        end
      end
      OP_UP: begin
        if (enables[0]) begin
          enables_next[1] = 1'b0;
          if (tilt_pos <= tilt_high) begin
            tilt_pos_next = tilt_pos + 10'd1;
            emit          = 1'b1;
            desc.value    = {{(VAL_W-REG_W){1'b0}}, tilt_pos_next};
          end else begin
            enables_next[0] = 1'b0;
          end
        end
      end
      OP_LEFT: begin
        if (enables[2]) begin
          enables_next[3] = 1'b0;
          if (pan_pos <= $signed({{(PAN_W-REG_W){1'b0}}, pan_high})) begin
            emit         = 1'b1;
            desc.id      = ID_PAN;
            desc.value   = {{(VAL_W-PAN_W){pan_pos[PAN_W-1]}}, pan_pos};
            pan_pos_next = pan_pos + 12'sd1;
          end else begin
            enables_next[2] = 1'b0;
          end
        end
      end
      OP_RIGHT: begin
        if (enables[3]) begin
          enables_next[2] = 1'b0;
          if (!pan_pos[PAN_W-1]) begin
            emit         = 1'b1;
            desc.id      = ID_PAN;
            desc.value   = {{(VAL_W-PAN_W){pan_pos[PAN_W-1]}}, pan_pos};
            pan_pos_next = pan_pos - 12'sd1;
          end else begin
            enables_next[3] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    desc.enables = enables_next;
  end

  assign q_push = accept && emit;
  assign q_desc = desc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_home  <= PAN_HOME_RST;
      tilt_home <= TILT_HOME_RST;
      tilt_low  <= TILT_LOW_RST;
      tilt_high <= TILT_HIGH_RST;
      pan_high  <= PAN_HIGH_RST;
      tilt_pos  <= TILT_HOME_RST;
      pan_pos   <= $signed({{(PAN_W-REG_W){1'b0}}, PAN_HOME_RST});
      enables   <= 4'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PAN_HOME:  pan_home  <= cfg_data;
          REG_TILT_HOME: tilt_home <= cfg_data;
          REG_TILT_LOW:  tilt_low  <= cfg_data;
          REG_TILT_HIGH: tilt_high <= cfg_data;
          REG_PAN_HIGH:  pan_high  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        tilt_pos <= tilt_pos_next;
        pan_pos  <= pan_pos_next;
        enables  <= enables_next;
      end
    end
  end

endmodule

/* rtl/ptsj_queue.sv */
// ptsj_queue: two-entry job queue between command decode and serializer
// depends on ptsj_pkg
module ptsj_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ptsj_pkg::desc_t       push_desc,
  input  logic                  pop,
  output ptsj_pkg::desc_t       head,
  output ptsj_pkg::q_status_t   status
);
  import ptsj_pkg::*;

  desc_t      mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head         = mem[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/ptsj_back.sv */
// ptsj_back: takes jobs from the queue and sends packet bytes through an output register
// depends on ptsj_pkg and ptsj_pkt_if
module ptsj_back (
  input  logic                clk,
  input  logic                rst,
  input  ptsj_pkg::desc_t     head,
  input  logic                q_empty,
  output logic                pop,
  ptsj_pkt_if.source          pkt
);
  import ptsj_pkg::*;

  desc_t             job;
  logic              busy;
  logic [BIDX_W-1:0] idx;
  logic              out_valid;
  logic [7:0]        out_byte;
  logic              last_byte;
  logic [3:0]        enables_now;
  logic              adv;
  logic              final_byte;
  logic              second;
  logic [BIDX_W-1:0] pos_wide;
  logic [7:0]        cur_id;
  logic [VAL_W-1:0]  cur_value;
  logic [7:0]        byte_now;

  assign adv        = busy && (!out_valid || pkt.ready);
  assign final_byte = job.pair ? (idx == LAST_PAIR) : (idx == LAST_SINGLE);
  assign pop        = !q_empty && (!busy || (adv && final_byte));

  assign second    = job.pair && (idx >= PKT_BYTES);
  assign pos_wide  = second ? idx - PKT_BYTES : idx;
  assign cur_id    = second ? ID_TILT : job.id;
  assign cur_value = second ? {{(VAL_W-REG_W){1'b0}}, job.tilt_value} : job.value;
  assign byte_now  = packet_byte(cur_id, cur_value, pos_wide[3:0]);

  assign pkt.valid       = out_valid;
  assign pkt.out_byte    = out_byte;
  assign pkt.last_byte   = last_byte;
  assign pkt.enables_now = enables_now;

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if (adv) begin
      out_byte    <= byte_now;
      last_byte   <= final_byte;
      enables_now <= job.enables;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (pkt.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (adv) begin
        if (final_byte) begin
          busy <= 1'b0;
        end
        idx <= idx + 5'd1;
      end
    end
  end

endmodule

/* rtl/pan_tilt_servo_jog_packetizer.sv */
// pan_tilt_servo_jog_packetizer: top level, command decode -> job queue -> byte serializer
// depends on ptsj_pkg, ptsj_if, ptsj_front, ptsj_queue, ptsj_back
//
//   channel  dir  handshake           payload
//   cmd      in   valid/ready         op[2:0], enable_bits[3:0]
//   pkt      out  valid/ready         out_byte[7:0], last_byte, enables_now[3:0]
//   cfg      in   cfg_we, no wait     cfg_index[2:0], cfg_data[9:0]
//
// a command is decoded in its accept cycle; a jog packet leaves as 9 bytes, a home command
// as 18 bytes, one byte per cycle while the pkt sink is ready; a queued job follows the
// last byte without a gap; a first byte passes the queue, job and output registers
// commands that send nothing push no job; a two-entry queue buffers jobs meanwhile
// sync active-high reset presets config and positions and clears flags, queue, out valid
// a stalled pkt sink holds the output register and, once the queue fills, cmd.ready
module pan_tilt_servo_jog_packetizer (
  input  logic        clk,
  input  logic        rst,
  ptsj_cmd_if.sink    cmd,
  ptsj_pkt_if.source  pkt,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import ptsj_pkg::*;

  logic      q_push;
  logic      q_pop;
  desc_t     q_in;
  desc_t     q_head;
  q_status_t q_stat;

  ptsj_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_stat.full),
    .q_push    (q_push),
    .q_desc    (q_in)
  );

  ptsj_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_stat)
  );

  ptsj_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_empty (q_stat.empty),
    .pop     (q_pop),
    .pkt     (pkt)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count != 2'd3)
    else $error("job queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("push into full job queue");

  a_packet_gapless: assert property (@(posedge clk) disable iff (rst)
    (pkt.valid && pkt.ready && !pkt.last_byte) |=> pkt.valid)
    else $error("gap inside a packet");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty job queue");
`endif

endmodule
